// ----- hw/rtl/rhp_pkg.sv -----
// Package for the RTP header parser: word types, status codes and header constants.
// Depends on nothing; every other file of the parser but rhp_in_if imports it.
package rhp_pkg;

  // Byte position counter width; the counter saturates at its all-ones value.
  localparam int POS_W = 19;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Width of the end offset of the CSRC list (12 + 4 * 15 = 72).
  localparam int CSRC_END_W = 7;

  // Fixed header layout.
  localparam int FIXED_HDR_LEN = 12;
  localparam int EXT_HDR_LEN = 4;
  localparam int EXT_LEN_HI_OFS = 2;
  localparam int EXT_LEN_LO_OFS = 3;
  localparam int SEQ_END = 4;
  localparam int STAMP_END = 8;
  localparam logic [1:0] RTP_VERSION = 2'd2;

  // Packet status, first failing check wins.
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_SHORT          = 3'd1,
    ST_BAD_VERSION    = 3'd2,
    ST_SHORT_CSRC     = 3'd3,
    ST_SHORT_EXT_HDR  = 3'd4,
    ST_SHORT_EXT_BODY = 3'd5
  } status_e;

  // One input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             is_payload;
    logic             packet_end;
    status_e          status;
    logic             marker_bit;
    logic [6:0]       payload_kind;
    logic [15:0]      seq_number;
    logic [31:0]      time_stamp;
    logic [31:0]      source_id;
    logic [3:0]       contributor_count;
    logic [1:0]       header_flags;
    logic [POS_W-1:0] header_length;
  } out_word_t;

endpackage

// ----- hw/rtl/rhp_in_if.sv -----
// Byte stream channel into the RTP header parser: valid, ready and one packet byte.
// Depends on no other file.
interface rhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/rhp_out_if.sv -----
// Result channel out of the RTP header parser: valid, ready and one decoded word.
// Depends on rhp_pkg.
interface rhp_out_if import rhp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [7:0]       payload_byte;
  logic             is_payload;
  logic             packet_end;
  logic [2:0]       status;
  logic             marker_bit;
  logic [6:0]       payload_kind;
  logic [15:0]      seq_number;
  logic [31:0]      time_stamp;
  logic [31:0]      source_id;
  logic [3:0]       contributor_count;
  logic [1:0]       header_flags;
  logic [POS_W-1:0] header_length;

  modport source (
    output valid, output payload_byte, output is_payload, output packet_end,
    output status, output marker_bit, output payload_kind, output seq_number,
    output time_stamp, output source_id, output contributor_count,
    output header_flags, output header_length, input ready
  );
  modport sink (
    input valid, input payload_byte, input is_payload, input packet_end,
    input status, input marker_bit, input payload_kind, input seq_number,
    input time_stamp, input source_id, input contributor_count,
    input header_flags, input header_length, output ready
  );
endinterface

// ----- hw/rtl/rhp_in_reg.sv -----
// Input register of the RTP header parser: holds one accepted byte until it is decoded.
// Depends on rhp_pkg.
module rhp_in_reg import rhp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_word_t word_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q;
  in_word_t word_q;

  // The register takes a new word when empty or when its word moves on.
  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Data holding register.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

// ----- hw/rtl/rhp_core.sv -----
// Decode core of the RTP header parser: header state, position counter and result logic.
// Depends on rhp_pkg.
module rhp_core import rhp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  output out_word_t result_o
);

  logic [POS_W-1:0]      pos_q, pos_d;
  logic [7:0]            first_q, first_d;
  logic [7:0]            second_q, second_d;
  logic [15:0]           seq_q, seq_d;
  logic [31:0]           stamp_q, stamp_d;
  logic [31:0]           source_q, source_d;
  logic [POS_W-1:0]      hdr_end_q, hdr_end_d;
  logic [15:0]           ext_words_q, ext_words_d;

  logic [7:0]            cur_byte;
  logic [7:0]            fb;
  logic [3:0]            cc;
  logic                  ext;
  logic                  v2;
  logic [CSRC_END_W-1:0] csrc_end;
  logic [POS_W-1:0]      csrc_end_w;
  logic [POS_W:0]        pkt_len;
  logic                  pay;
  status_e               status;

  // Field decode and next header state.
  always_comb begin
    cur_byte   = word_i.in_byte;
    fb         = (pos_q == '0) ? cur_byte : first_q;
    cc         = fb[3:0];
    ext        = fb[4];
    v2         = (fb[7:6] == RTP_VERSION);
    csrc_end   = CSRC_END_W'(FIXED_HDR_LEN) + {1'b0, cc, 2'b00};
    csrc_end_w = POS_W'(csrc_end);

    first_d     = first_q;
    second_d    = second_q;
    seq_d       = seq_q;
    stamp_d     = stamp_q;
    source_d    = source_q;
    hdr_end_d   = hdr_end_q;
    ext_words_d = ext_words_q;

    // Fixed header bytes are shifted in by position.
    if (pos_q == '0) begin
      first_d   = cur_byte;
      hdr_end_d = csrc_end_w + (ext ? POS_W'(EXT_HDR_LEN) : '0);
    end else if (pos_q == POS_W'(1)) begin
      second_d = cur_byte;
    end else if (pos_q < POS_W'(SEQ_END)) begin
      seq_d = {seq_q[7:0], cur_byte};
    end else if (pos_q < POS_W'(STAMP_END)) begin
      stamp_d = {stamp_q[23:0], cur_byte};
    end else if (pos_q < POS_W'(FIXED_HDR_LEN)) begin
      source_d = {source_q[23:0], cur_byte};
    end

    // Extension word count follows the two-byte profile field.
    if (ext && pos_q == csrc_end_w + POS_W'(EXT_LEN_HI_OFS)) begin
      ext_words_d = {8'h00, cur_byte};
    end
    if (ext && pos_q == csrc_end_w + POS_W'(EXT_LEN_LO_OFS)) begin
      ext_words_d = {ext_words_q[7:0], cur_byte};
      hdr_end_d   = csrc_end_w + POS_W'(EXT_HDR_LEN) + POS_W'({ext_words_d, 2'b00});
    end

    // Payload starts at the stored header end; it never moves onto the current byte.
    pay     = v2 && (pos_q >= hdr_end_q);
    pkt_len = {1'b0, pos_q} + (POS_W + 1)'(1);

    // Status checks in priority order.
    if (pkt_len < (POS_W + 1)'(FIXED_HDR_LEN)) begin
      status = ST_SHORT;
    end else if (!v2) begin
      status = ST_BAD_VERSION;
    end else if (pkt_len < (POS_W + 1)'(csrc_end)) begin
      status = ST_SHORT_CSRC;
    end else if (ext && pkt_len < (POS_W + 1)'(csrc_end) + (POS_W + 1)'(EXT_HDR_LEN)) begin
      status = ST_SHORT_EXT_HDR;
    end else if (ext && pkt_len < {1'b0, hdr_end_d}) begin
      status = ST_SHORT_EXT_BODY;
    end else begin
      status = ST_OK;
    end

    // Result word; summary fields only on the last byte.
    result_o              = '0;
    result_o.status       = ST_OK;
    result_o.payload_byte = pay ? cur_byte : 8'h00;
    result_o.is_payload   = pay;
    result_o.packet_end   = word_i.last_byte;
    if (word_i.last_byte) begin
      result_o.status            = status;
      result_o.marker_bit        = second_d[7];
      result_o.payload_kind      = second_d[6:0];
      result_o.seq_number        = seq_d;
      result_o.time_stamp        = stamp_d;
      result_o.source_id         = source_d;
      result_o.contributor_count = cc;
      result_o.header_flags      = {fb[5], ext};
      result_o.header_length     = hdr_end_d;
    end

    // Saturating position counter.
    pos_d = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
  end

  // Header state; the last byte of a packet returns it to the reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      first_q     <= '0;
      second_q    <= '0;
      seq_q       <= '0;
      stamp_q     <= '0;
      source_q    <= '0;
      hdr_end_q   <= POS_W'(FIXED_HDR_LEN);
      ext_words_q <= '0;
    end else if (step_i) begin
      if (word_i.last_byte) begin
        pos_q       <= '0;
        first_q     <= '0;
        second_q    <= '0;
        seq_q       <= '0;
        stamp_q     <= '0;
        source_q    <= '0;
        hdr_end_q   <= POS_W'(FIXED_HDR_LEN);
        ext_words_q <= '0;
      end else begin
        pos_q       <= pos_d;
        first_q     <= first_d;
        second_q    <= second_d;
        seq_q       <= seq_d;
        stamp_q     <= stamp_d;
        source_q    <= source_d;
        hdr_end_q   <= hdr_end_d;
        ext_words_q <= ext_words_d;
      end
    end
  end

`ifndef SYNTHESIS
  // A packet end re-arms the position counter.
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && word_i.last_byte |=> pos_q == '0)
    else $error("position counter not cleared after packet end");

  // Payload never lies inside the fixed header.
  a_pay_past_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.is_payload |-> pos_q >= POS_W'(FIXED_HDR_LEN))
    else $error("payload flagged inside the fixed header");

  // The header end never shrinks below the fixed header.
  a_hdr_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_end_q >= POS_W'(FIXED_HDR_LEN))
    else $error("header end below fixed header length");
`endif

endmodule

// ----- hw/rtl/rhp_out_reg.sv -----
// Result register of the RTP header parser: holds one decoded word for the consumer.
// Depends on rhp_pkg.
module rhp_out_reg import rhp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_word_t word_i,
  output logic      free_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_word_t word_o
);

  logic      valid_q;
  out_word_t word_q;

  // The register can load when empty or when its word is taken this cycle.
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result holding register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

endmodule

// ----- hw/rtl/rtp_header_parser.sv -----
// Top level of the RTP fixed header parser: input register, decode core, result register.
// Depends on rhp_pkg, rhp_in_if, rhp_out_if, rhp_in_reg, rhp_core and rhp_out_reg.
//
//   channel | port  | word                            | direction
//   --------+-------+---------------------------------+----------
//   bytes   | in_i  | in_byte, last_byte              | in
//   results | out_o | payload flags, header summary   | out
//
// One byte is accepted every cycle while out_o does not stall; the byte is held in the
// input register, and its result word is valid once loaded into the result register.
// The decode core updates the header state once per byte as it moves from the
// input register into the result register, so one word is in flight per register.
// Reset clears both registers and returns the header state to an empty packet.
// A stall on out_o backs up through the result and input registers to in_i.ready.
module rtp_header_parser import rhp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rhp_in_if.sink    in_i,
  rhp_out_if.source out_o
);

  in_word_t  in_word;
  in_word_t  held_word;
  out_word_t core_word;
  out_word_t res_word;
  logic      held_valid;
  logic      out_free;
  logic      advance;

  assign in_word.in_byte   = in_i.in_byte;
  assign in_word.last_byte = in_i.last_byte;

  // A held byte is decoded when the result register can take its word.
  assign advance = held_valid && out_free;

  rhp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .word_i    (in_word),
    .advance_i (advance),
    .valid_o   (held_valid),
    .word_o    (held_word)
  );

  rhp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (held_word),
    .result_o (core_word)
  );

  rhp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .word_i  (core_word),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .word_o  (res_word)
  );

  // Result word onto the output channel.
  assign out_o.payload_byte      = res_word.payload_byte;
  assign out_o.is_payload        = res_word.is_payload;
  assign out_o.packet_end        = res_word.packet_end;
  assign out_o.status            = res_word.status;
  assign out_o.marker_bit        = res_word.marker_bit;
  assign out_o.payload_kind      = res_word.payload_kind;
  assign out_o.seq_number        = res_word.seq_number;
  assign out_o.time_stamp        = res_word.time_stamp;
  assign out_o.source_id         = res_word.source_id;
  assign out_o.contributor_count = res_word.contributor_count;
  assign out_o.header_flags      = res_word.header_flags;
  assign out_o.header_length     = res_word.header_length;

`ifndef SYNTHESIS
  // A full input register facing a blocked result register refuses new bytes.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid && !out_free |-> !in_i.ready)
    else $error("byte accepted while the pipeline is blocked");

  // A decoded byte always lands in the result register.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_o.valid)
    else $error("decoded word lost");

  // A byte taken into an empty pipeline is decoded in the next cycle.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && !held_valid && !out_o.valid |=> advance)
    else $error("held byte not decoded");
`endif

endmodule
